### rtl/f12cw_pkg.sv
// Shared types and constants for the FAT12 cluster chain walker.
`default_nettype none
package f12cw_pkg;

  localparam int TABLE_ENTRIES = 4096;
  localparam int TABLE_BYTES   = (TABLE_ENTRIES * 3 + 1) / 2;
  localparam int ADDR_W        = 13;
  localparam int MAX_CHAIN     = 64;
  localparam int CNT_W         = 7;
  localparam int CFG_IDX_W     = 1;
  localparam int CFG_DATA_W    = 23;

  localparam logic [11:0] CHAIN_END = 12'hFF8;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_WALK = 1'b1;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_EMPTY  = 2'd1;
  localparam logic [1:0] ST_BEYOND = 2'd2;
  localparam logic [1:0] ST_TRUNC  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_AREA_START = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPC        = 1'd1;

  typedef struct packed {
    logic        kind;
    logic [12:0] byte_address;
    logic [7:0]  byte_value;
    logic [11:0] head_cluster;
  } in_item_t;

  typedef struct packed {
    logic [11:0] cluster;
    logic [23:0] start_sector;
    logic [1:0]  status;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic       write_byte;
    logic       start_walk;
    logic       fetch;
    logic       emit;
    logic [1:0] emit_status;
    logic       emit_last;
    logic       advance;
  } dp_cmd_t;

  typedef struct packed {
    logic first_bad;
    logic beyond;
    logic chain_end;
    logic chain_full;
  } dp_sts_t;

endpackage
`default_nettype wire

### rtl/f12cw_ctrl.sv
// Controller state machine that sequences table loads and chain walks.
`default_nettype none
module f12cw_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire logic                 in_kind,
  input  wire f12cw_pkg::dp_sts_t   sts,
  output logic                      busy,
  output f12cw_pkg::dp_cmd_t        cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_EVAL
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r, busy_nxt;
  logic   accept;

  assign accept = start && !busy_r;
  assign busy   = busy_r;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_kind == f12cw_pkg::KIND_LOAD) begin
            cmd.write_byte = 1'b1;
          end else if (sts.first_bad) begin
            cmd.emit        = 1'b1;
            cmd.emit_status = f12cw_pkg::ST_EMPTY;
            cmd.emit_last   = 1'b1;
          end else begin
            cmd.start_walk = 1'b1;
            state_nxt      = S_READ;
          end
        end
      end
      S_READ: begin
        cmd.fetch = 1'b1;
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        cmd.emit = 1'b1;
        if (sts.beyond) begin
          cmd.emit_status = f12cw_pkg::ST_BEYOND;
          cmd.emit_last   = 1'b1;
          state_nxt       = S_IDLE;
        end else if (sts.chain_end) begin
          cmd.emit_status = f12cw_pkg::ST_OK;
          cmd.emit_last   = 1'b1;
          state_nxt       = S_IDLE;
        end else if (sts.chain_full) begin
          cmd.emit_status = f12cw_pkg::ST_TRUNC;
          cmd.emit_last   = 1'b1;
          state_nxt       = S_IDLE;
        end else begin
          cmd.emit_status = f12cw_pkg::ST_OK;
          cmd.advance     = 1'b1;
          state_nxt       = S_READ;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    busy_nxt = (state_nxt != S_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      busy_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      busy_r  <= busy_nxt;
    end
  end

endmodule
`default_nettype wire

### rtl/f12cw_dp.sv
// Datapath with the table memory, chain registers, sector arithmetic and result register.
`default_nettype none
module f12cw_dp (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire f12cw_pkg::in_item_t                   in_item,
  input  wire f12cw_pkg::dp_cmd_t                    cmd,
  input  wire logic                                  cfg_we,
  input  wire logic [f12cw_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [f12cw_pkg::CFG_DATA_W-1:0]      cfg_data,
  output f12cw_pkg::dp_sts_t                         sts,
  output logic                                       out_strobe,
  output f12cw_pkg::out_item_t                       out_item
);

  logic [7:0]  mem [f12cw_pkg::TABLE_BYTES];

  logic [22:0] area_r;
  logic [7:0]  spc_r;
  logic [11:0] cl_r, cl_nxt;
  logic [f12cw_pkg::CNT_W-1:0] cnt_r;
  logic [7:0]  lo_r, hi_r;
  logic [23:0] prod_r;
  logic        out_strobe_r;
  f12cw_pkg::out_item_t out_item_r;

  logic [f12cw_pkg::ADDR_W-1:0] off;
  logic [f12cw_pkg::ADDR_W-1:0] off_p1;
  logic [23:0] sector;

  assign off    = f12cw_pkg::ADDR_W'({1'b0, cl_r}) + f12cw_pkg::ADDR_W'(cl_r >> 1);
  assign off_p1 = off + f12cw_pkg::ADDR_W'(1);

  assign cl_nxt = cl_r[0] ? {hi_r, lo_r[7:4]} : {hi_r[3:0], lo_r};

  assign sts.first_bad  = (in_item.head_cluster < 12'd2) ||
                          (in_item.head_cluster >= f12cw_pkg::CHAIN_END);
  assign sts.beyond     = ({1'b0, cl_r} >= 13'(f12cw_pkg::TABLE_ENTRIES)) ||
                          (({1'b0, off} + 14'd1) >= 14'(f12cw_pkg::TABLE_BYTES));
  assign sts.chain_end  = (cl_nxt >= f12cw_pkg::CHAIN_END);
  assign sts.chain_full = (cnt_r == f12cw_pkg::CNT_W'(f12cw_pkg::MAX_CHAIN - 1));

  assign sector = 24'({1'b0, area_r}) + prod_r;

  always_ff @(posedge clk) begin
    if (cmd.write_byte &&
        ({1'b0, in_item.byte_address} < 14'(f12cw_pkg::TABLE_BYTES))) begin
      mem[in_item.byte_address] <= in_item.byte_value;
    end
    if (cmd.fetch) begin
      lo_r <= mem[off];
      hi_r <= mem[off_p1];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fetch) begin
      prod_r <= 24'((24'(cl_r) - 24'd2) * {16'd0, spc_r});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      area_r <= '0;
      spc_r  <= 8'd1;
    end else if (cfg_we) begin
      if (cfg_index == f12cw_pkg::CFG_AREA_START) begin
        area_r <= cfg_data;
      end else if (cfg_index == f12cw_pkg::CFG_SPC) begin
        spc_r <= cfg_data[7:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cl_r  <= '0;
      cnt_r <= '0;
    end else if (cmd.start_walk) begin
      cl_r  <= in_item.head_cluster;
      cnt_r <= '0;
    end else if (cmd.advance) begin
      cl_r  <= cl_nxt;
      cnt_r <= cnt_r + f12cw_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= cmd.emit;
    end
    if (cmd.emit) begin
      if (cmd.emit_status == f12cw_pkg::ST_EMPTY) begin
        out_item_r.cluster      <= '0;
        out_item_r.start_sector <= '0;
      end else begin
        out_item_r.cluster      <= cl_r;
        out_item_r.start_sector <= sector;
      end
      out_item_r.status <= cmd.emit_status;
      out_item_r.last   <= cmd.emit_last;
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

endmodule
`default_nettype wire

### rtl/fat12_cluster_chain_walker_top.sv
// Top level of the FAT12 cluster chain walker.
//
//   Channel  Handshake              Payload
//   input    start / busy           in_item   (kind, byte_address, byte_value, head_cluster)
//   result   out_strobe             out_item  (cluster, start_sector, status, last)
//   config   cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A table load leaves busy low, so loads may follow every cycle while no walk holds busy.
// A walk with an empty first cluster gives a registered result without raising busy.
// Other walks raise busy and run a two-step loop of memory read and evaluate for each chain
// link; results come one per link.
// Reset (synchronous, active low) clears control, chain and area state; spc resets to 1.
// Results are shown for a single cycle and cannot be stalled by the receiver.
`default_nettype none
module fat12_cluster_chain_walker_top (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  start,
  output logic                                       busy,
  input  wire f12cw_pkg::in_item_t                   in_item,
  output logic                                       out_strobe,
  output f12cw_pkg::out_item_t                       out_item,
  input  wire logic                                  cfg_valid,
  output logic                                       cfg_ready,
  input  wire logic [f12cw_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [f12cw_pkg::CFG_DATA_W-1:0]      cfg_data
);

  f12cw_pkg::dp_cmd_t cmd;
  f12cw_pkg::dp_sts_t sts;

  assign cfg_ready = 1'b1;

  f12cw_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_kind (in_item.kind),
    .sts     (sts),
    .busy    (busy),
    .cmd     (cmd)
  );

  f12cw_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_item    (in_item),
    .cmd        (cmd),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .sts        (sts),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

endmodule
`default_nettype wire

### dv/f12cw_chain_checker.sv
`timescale 1ns / 100ps
// Checker that mirrors the table and registers, predicts each walk and compares results.
module f12cw_chain_checker
  import f12cw_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic                  busy,
  input  in_item_t              in_item,
  input  logic                  out_strobe,
  input  out_item_t             out_item,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    fail_count,
  output int                    pending
);

  logic [7:0]  fat_bytes [TABLE_BYTES];
  logic [22:0] area_start;
  logic [7:0]  spc;
  out_item_t   chain_results [$];
  out_item_t   want;

  initial begin
    fail_count = 0;
    pending = 0;
  end

  function automatic logic [23:0] start_sector_of(input logic [11:0] cl);
    logic [31:0] offset;
    offset = (32'(cl) - 32'd2) * 32'(spc);
    return 24'(32'(area_start) + offset);
  endfunction

  function automatic void follow_chain(input logic [11:0] first);
    out_item_t   r;
    logic [11:0] cl;
    logic [11:0] link;
    int          off;
    int          n;
    bit          done;
    if (first < 12'd2 || first >= CHAIN_END) begin
      r.cluster = '0;
      r.start_sector = '0;
      r.status = ST_EMPTY;
      r.last = 1'b1;
      chain_results.push_back(r);
      return;
    end
    cl = first;
    n = 0;
    done = 1'b0;
    while (!done) begin
      off = int'(cl) + int'(cl) / 2;
      link = '0;
      r.cluster = cl;
      r.start_sector = start_sector_of(cl);
      r.last = 1'b1;
      if (int'(cl) >= TABLE_ENTRIES || off + 1 >= TABLE_BYTES) begin
        r.status = ST_BEYOND;
        done = 1'b1;
      end else begin
        if (cl[0]) begin
          link = {fat_bytes[off + 1], fat_bytes[off][7:4]};
        end else begin
          link = {fat_bytes[off + 1][3:0], fat_bytes[off]};
        end
        if (link >= CHAIN_END) begin
          r.status = ST_OK;
          done = 1'b1;
        end else if (n + 1 >= MAX_CHAIN) begin
          r.status = ST_TRUNC;
          done = 1'b1;
        end else begin
          r.status = ST_OK;
          r.last = 1'b0;
        end
      end
      chain_results.push_back(r);
      n++;
      cl = link;
    end
  endfunction

  task automatic check_field(input string name, input logic [31:0] want_v,
                             input logic [31:0] got_v);
    if (want_v !== got_v) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, want_v, got_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      chain_results.delete();
      area_start = '0;
      spc = 8'd1;
    end else begin
      if (out_strobe) begin
        if (chain_results.size() == 0) begin
          $error("cluster: expected no item, actual 0x%0h", out_item.cluster);
          fail_count++;
        end else begin
          want = chain_results.pop_front();
          check_field("cluster", 32'(want.cluster), 32'(out_item.cluster));
          check_field("start_sector", 32'(want.start_sector), 32'(out_item.start_sector));
          check_field("status", 32'(want.status), 32'(out_item.status));
          check_field("last", 32'(want.last), 32'(out_item.last));
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_AREA_START) begin
          area_start = cfg_data;
        end else if (cfg_index == CFG_SPC) begin
          spc = cfg_data[7:0];
        end
      end
      if (start && !busy) begin
        if (in_item.kind == KIND_LOAD) begin
          if (in_item.byte_address < TABLE_BYTES) begin
            fat_bytes[in_item.byte_address] = in_item.byte_value;
          end
        end else begin
          follow_chain(in_item.head_cluster);
        end
      end
    end
    pending = chain_results.size();
  end

endmodule

### dv/tb_fat12_cluster_chain_walker_top.sv
`timescale 1ns / 100ps
// Testbench top: table loads, chain walks and register writes, and the verdict.
module tb_fat12_cluster_chain_walker_top;
  import f12cw_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int PHASE_ITEMS = 60;

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  in_item_t              in_item = '0;
  logic                  out_strobe;
  out_item_t             out_item;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  int                    fail_count;
  int                    pending;
  int                    gap_pct = 38;
  int                    stall_cycles = 0;
  int                    items_sent = 0;
  bit   [7:0]            shadow [TABLE_BYTES];
  bit                    filled [TABLE_BYTES];

  fat12_cluster_chain_walker_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_strobe (out_strobe),
    .out_item   (out_item),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  f12cw_chain_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_strobe (out_strobe),
    .out_item   (out_item),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_strobe || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles + 1 >= STALL_LIMIT) begin
      $display("tb_fat12_cluster_chain_walker_top failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic issue(input in_item_t item);
    logic taken;
    while (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_item <= item;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = !busy;
      @(posedge clk);
    end
  endtask

  task automatic load_byte(input logic [12:0] addr, input logic [7:0] value);
    in_item_t item;
    item.kind = KIND_LOAD;
    item.byte_address = addr;
    item.byte_value = value;
    item.head_cluster = 12'($urandom);
    issue(item);
    items_sent++;
    if (addr < TABLE_BYTES) begin
      shadow[addr] = value;
      filled[addr] = 1'b1;
    end
  endtask

  // True when the walk from this cluster reads only table bytes that have been loaded.
  function automatic bit chain_safe(input logic [11:0] head);
    logic [11:0] cl;
    logic [11:0] link;
    int          off;
    bit          safe;
    bit          done;
    safe = 1'b1;
    done = (head < 12'd2) || (head >= CHAIN_END);
    cl = head;
    for (int n = 0; n < MAX_CHAIN && !done; n++) begin
      off = int'(cl) + int'(cl) / 2;
      if (int'(cl) >= TABLE_ENTRIES || off + 1 >= TABLE_BYTES) begin
        done = 1'b1;
      end else if (!filled[off] || !filled[off + 1]) begin
        safe = 1'b0;
        done = 1'b1;
      end else begin
        link = cl[0] ? {shadow[off + 1], shadow[off][7:4]} :
                       {shadow[off + 1][3:0], shadow[off]};
        done = (link >= CHAIN_END);
        cl = link;
      end
    end
    return safe;
  endfunction

  task automatic walk_chain(input logic [11:0] first);
    in_item_t item;
    if (chain_safe(first)) begin
      item.kind = KIND_WALK;
      item.byte_address = 13'($urandom);
      item.byte_value = 8'($urandom);
      item.head_cluster = first;
      issue(item);
      items_sent++;
    end
  endtask

  // Rewrites one packed 12-bit entry, keeping the nibble that belongs to its neighbour.
  task automatic set_entry(input logic [11:0] n, input logic [11:0] v);
    int off;
    off = int'(n) + int'(n) / 2;
    if (n[0]) begin
      load_byte(13'(off), {v[3:0], shadow[off][3:0]});
      load_byte(13'(off + 1), v[11:4]);
    end else begin
      load_byte(13'(off), v[7:0]);
      load_byte(13'(off + 1), {shadow[off + 1][7:4], v[11:8]});
    end
  endtask

  task automatic build_chain();
    logic [11:0] path [$];
    bit          used [4096];
    logic [11:0] cl;
    logic [11:0] tail;
    int          len;
    int          pick;
    for (int i = 0; i < 4096; i++) used[i] = 1'b0;
    pick = $urandom_range(99);
    if (pick < 4) begin
      len = $urandom_range(64, 70);
    end else if (pick < 15) begin
      len = $urandom_range(9, 20);
    end else begin
      len = $urandom_range(1, 6);
    end
    while (path.size() < len) begin
      cl = 12'($urandom_range(2, 4095));
      if (!used[cl]) begin
        used[cl] = 1'b1;
        path.push_back(cl);
      end
    end
    pick = $urandom_range(99);
    if (pick < 70) begin
      tail = 12'($urandom_range(12'hFF8, 12'hFFF));
    end else if (pick < 80) begin
      tail = 12'($urandom_range(0, 1));
    end else if (pick < 90) begin
      tail = path[0];
    end else begin
      tail = 12'($urandom_range(2, 4095));
    end
    for (int i = 0; i < len; i++) begin
      set_entry(path[i], (i + 1 < len) ? path[i + 1] : tail);
    end
    walk_chain(path[0]);
    walk_chain(path[$urandom_range(0, len - 1)]);
  endtask

  task automatic cfg_put(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    logic taken;
    while (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
      cfg_valid <= 1'b0;
      @(posedge clk);
    end
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = cfg_ready;
      @(posedge clk);
    end
  endtask

  task automatic set_geometry(input logic [22:0] area, input logic [7:0] spc);
    cfg_put(CFG_AREA_START, area);
    cfg_put(CFG_SPC, {15'($urandom), spc});
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Holds the input off until every predicted result has come and the walker is quiet.
  task automatic settle();
    logic quiet;
    start <= 1'b0;
    @(posedge clk);
    quiet = 1'b0;
    while (!quiet) begin
      @(negedge clk);
      quiet = (pending == 0) && !busy;
      @(posedge clk);
    end
    repeat (6) @(posedge clk);
  endtask

  task automatic random_phase();
    int goal;
    int pick;
    goal = items_sent + PHASE_ITEMS;
    while (items_sent < goal) begin
      pick = $urandom_range(99);
      if (pick < 60) begin
        build_chain();
      end else if (pick < 74) begin
        walk_chain(12'($urandom));
      end else if (pick < 88) begin
        load_byte(13'($urandom), 8'($urandom));
      end else if (pick < 97) begin
        if (pick[0]) begin
          walk_chain(12'($urandom_range(0, 1)));
        end else begin
          walk_chain(12'($urandom_range(12'hFF8, 12'hFFF)));
        end
      end else begin
        settle();
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    set_geometry(23'h7FFFFF, 8'd128);

    walk_chain(12'd0);
    walk_chain(12'd1);
    walk_chain(12'hFF8);
    walk_chain(12'hFFF);
    load_byte(13'h1FFF, 8'h00);
    load_byte(13'(TABLE_BYTES), 8'hA5);
    set_entry(12'd0, 12'hFF8);
    set_entry(12'd1, 12'hFFF);
    set_entry(12'd2, 12'd3);
    set_entry(12'd3, 12'hFF8);
    walk_chain(12'd2);
    set_entry(12'd5, 12'd5);
    walk_chain(12'd5);
    set_entry(12'd7, 12'd1);
    walk_chain(12'd7);
    set_entry(12'd4095, 12'hFFF);
    walk_chain(12'd4095);
    set_entry(12'd4094, 12'd4095);
    walk_chain(12'd4094);

    settle();
    set_geometry(23'd0, 8'd1);
    random_phase();
    settle();
    set_geometry(23'h7FFFFF, 8'd128);
    random_phase();
    settle();
    set_geometry(23'($urandom), 8'd1 << $urandom_range(0, 7));
    gap_pct = 0;
    random_phase();
    gap_pct = 38;
    settle();
    set_geometry(23'($urandom), 8'hFF);
    random_phase();
    settle();
    set_geometry(23'($urandom), 8'd0);
    random_phase();
    settle();
    set_geometry(23'($urandom), 8'd3);
    random_phase();
    settle();

    repeat (10) @(posedge clk);
    @(negedge clk);
    if (fail_count == 0) begin
      $display("tb_fat12_cluster_chain_walker_top passed");
    end else begin
      $display("tb_fat12_cluster_chain_walker_top failed");
    end
    $finish;
  end

endmodule
